@@ rtl/u8cc_pkg.sv @@
// shared types, constants and decode/fold functions for the caseless utf-8 compare
package u8cc_pkg;

  localparam int unsigned CpW    = 21;
  localparam int unsigned DiffW  = 22;
  localparam int unsigned AdvW   = 3;
  localparam int unsigned LenW   = 3;
  localparam int unsigned SdiffW = 4;

  localparam logic [CpW-1:0] CpReplace = 21'h00fffd;

  localparam logic [LenW-1:0] LenInvalid = 3'd0;
  localparam logic [LenW-1:0] LenOne     = 3'd1;
  localparam logic [LenW-1:0] LenTwo     = 3'd2;
  localparam logic [LenW-1:0] LenThree   = 3'd3;
  localparam logic [LenW-1:0] LenFour    = 3'd4;

  localparam logic [4:0] LeadTwoMask = 5'h18;
  localparam logic [4:0] LeadThree   = 5'h1c;
  localparam logic [4:0] LeadFour    = 5'h1e;

  typedef struct packed {
    logic                     special;
    logic signed [SdiffW-1:0] sdiff;
    logic [CpW-1:0]           ca;
    logic [CpW-1:0]           cb;
    logic [AdvW-1:0]          adv_a;
    logic [AdvW-1:0]          adv_b;
  } u8cc_stage_t;

  typedef struct packed {
    logic [2:0]            pad;
    logic [AdvW-1:0]       advance_b;
    logic [AdvW-1:0]       advance_a;
    logic signed [DiffW-1:0] difference;
    logic                  decided;
  } u8cc_out_t;

  function automatic logic [LenW-1:0] lead_len(input logic [7:0] b);
    logic [LenW-1:0] len;
    len = LenInvalid;
    if (!b[7]) begin
      len = LenOne;
    end else if (b[7:5] == LeadTwoMask[4:2]) begin
      len = LenTwo;
    end else if (b[7:4] == LeadThree[4:1]) begin
      len = LenThree;
    end else if (b[7:3] == LeadFour) begin
      len = LenFour;
    end
    return len;
  endfunction

  function automatic logic [CpW-1:0] decode_cp(input logic [31:0] w, input logic [LenW-1:0] len);
    logic [7:0]     b0, b1, b2, b3;
    logic [CpW-1:0] cp;
    b0 = w[7:0];
    b1 = w[15:8];
    b2 = w[23:16];
    b3 = w[31:24];
    cp = CpReplace;
    unique case (len)
      LenOne: begin
        cp = {13'd0, b0};
      end
      LenTwo: begin
        if (b1 != 8'd0) cp = {10'd0, b0[4:0], b1[5:0]};
      end
      LenThree: begin
        if (b1 != 8'd0 && b2 != 8'd0) cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      end
      LenFour: begin
        if (b1 != 8'd0 && b2 != 8'd0 && b3 != 8'd0) begin
          cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        end
      end
      default: cp = CpReplace;
    endcase
    return cp;
  endfunction

  function automatic logic [AdvW-1:0] step_len(input logic [31:0] w, input logic [LenW-1:0] len);
    logic [AdvW-1:0] n;
    logic            run;
    n   = '0;
    run = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (run && (LenW'(i) < len) && (w[8*i +: 8] != 8'd0)) begin
        n = n + AdvW'(1);
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  function automatic logic in_rng(input logic [CpW-1:0] c, input logic [CpW-1:0] lo,
                                  input logic [CpW-1:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic logic [CpW-1:0] fold_latin(input logic [CpW-1:0] c);
    logic [CpW-1:0] r;
    r = c;
    if (in_rng(c, 21'h41, 21'h5a) || in_rng(c, 21'hc0, 21'hd6) || in_rng(c, 21'hd8, 21'hde)) begin
      r = c + CpW'(32);
    end else if (in_rng(c, 21'h100, 21'h12f) || in_rng(c, 21'h132, 21'h137) ||
                 in_rng(c, 21'h14a, 21'h177) || in_rng(c, 21'h182, 21'h185) ||
                 in_rng(c, 21'h1a0, 21'h1a5) || in_rng(c, 21'h1de, 21'h1ef) ||
                 in_rng(c, 21'h1f8, 21'h21f) || in_rng(c, 21'h222, 21'h233) ||
                 in_rng(c, 21'h246, 21'h24f)) begin
      r = {c[CpW-1:1], 1'b0};
    end else if (in_rng(c, 21'h139, 21'h148) || in_rng(c, 21'h179, 21'h17e) ||
                 in_rng(c, 21'h1b3, 21'h1b6) || in_rng(c, 21'h1cd, 21'h1dc)) begin
      r = c + CpW'(1);
      r[0] = 1'b0;
    end else begin
      unique case (c)
        21'h178: r = 21'h0ff;
        21'h187: r = 21'h188;
        21'h18b: r = 21'h18c;
        21'h18e: r = 21'h1dd;
        21'h191: r = 21'h192;
        21'h198: r = 21'h199;
        21'h1a7: r = 21'h1a8;
        21'h1ac: r = 21'h1ad;
        21'h1af: r = 21'h1b0;
        21'h1b7: r = 21'h292;
        21'h1b8: r = 21'h1b9;
        21'h1bc: r = 21'h1bd;
        21'h1c4, 21'h1c5: r = 21'h1c6;
        21'h1c7, 21'h1c8: r = 21'h1c9;
        21'h1ca, 21'h1cb: r = 21'h1cc;
        21'h1f1, 21'h1f2: r = 21'h1f3;
        21'h1f4: r = 21'h1f5;
        21'h1f7: r = 21'h1bf;
        21'h220: r = 21'h19e;
        21'h23b: r = 21'h23c;
        21'h23d: r = 21'h19a;
        21'h241: r = 21'h242;
        21'h243: r = 21'h180;
        default: r = c;
      endcase
    end
    return r;
  endfunction

endpackage

@@ rtl/utf8_caseless_char_compare_core.sv @@
// caseless utf-8 character pair compare, three-stage pipeline
// stages in order from input accept to result valid: decode, fold, subtract, each registered
// throughput: one item per cycle while out_tready is high; each stage holds one item with its own valid bit
// a stalled output holds its stage and back-pressure fills the earlier stages
// reset: rst_n synchronous active low clears all valid bits, payload is not reset
module utf8_caseless_char_compare_core
  import u8cc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // bytes_a[31:0], bytes_b[63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // decided[0], difference[22:1], advance_a[25:23], advance_b[28:26]
);

  logic        v1_r, v2_r, v3_r;
  logic        v1_nxt, v2_nxt, v3_nxt;
  logic        rdy1, rdy2, rdy3;
  u8cc_stage_t s1_r, s1_nxt, s2_r, s2_nxt;
  u8cc_out_t   s3_r, s3_nxt;

  logic [31:0]     wa, wb;
  logic [7:0]      a0, b0;
  logic [LenW-1:0] la, lb;
  logic [DiffW-1:0] cdiff;

  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  // stage 1: terminators, lengths, decode
  always_comb begin
    wa = in_tdata[31:0];
    wb = in_tdata[63:32];
    a0 = wa[7:0];
    b0 = wb[7:0];
    la = lead_len(a0);
    lb = lead_len(b0);
    s1_nxt.special = 1'b0;
    s1_nxt.sdiff   = '0;
    if (a0 == 8'd0 && b0 == 8'd0) begin
      s1_nxt.special = 1'b1;
    end else if (a0 == 8'd0) begin
      s1_nxt.special = 1'b1;
      s1_nxt.sdiff   = SdiffW'(1);
    end else if (b0 == 8'd0) begin
      s1_nxt.special = 1'b1;
      s1_nxt.sdiff   = -SdiffW'(1);
    end else if (la == LenInvalid || lb == LenInvalid) begin
      s1_nxt.special = 1'b1;
      s1_nxt.sdiff   = SdiffW'({1'b0, la}) - SdiffW'({1'b0, lb});
    end
    s1_nxt.ca    = decode_cp(wa, la);
    s1_nxt.cb    = decode_cp(wb, lb);
    s1_nxt.adv_a = step_len(wa, la);
    s1_nxt.adv_b = step_len(wb, lb);
    v1_nxt       = rdy1 ? in_tvalid : v1_r;
  end

  // stage 2: case folding
  always_comb begin
    s2_nxt    = s1_r;
    s2_nxt.ca = fold_latin(s1_r.ca);
    s2_nxt.cb = fold_latin(s1_r.cb);
    v2_nxt    = rdy2 ? v1_r : v2_r;
  end

  // stage 3: subtract and decide
  always_comb begin
    cdiff  = {1'b0, s2_r.ca} - {1'b0, s2_r.cb};
    s3_nxt = '0;
    if (s2_r.special) begin
      s3_nxt.decided    = 1'b1;
      s3_nxt.difference = DiffW'(signed'(s2_r.sdiff));
    end else if (cdiff != '0) begin
      s3_nxt.decided    = 1'b1;
      s3_nxt.difference = cdiff;
    end else begin
      s3_nxt.advance_a = s2_r.adv_a;
      s3_nxt.advance_b = s2_r.adv_b;
    end
    v3_nxt = rdy3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= s1_nxt;
    if (rdy2) s2_r <= s2_nxt;
    if (rdy3) s3_r <= s3_nxt;
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = s3_r;

`ifndef SYNTHESIS
  a_decided_no_advance: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[28:23] == 6'd0)
    else $error("decided item with nonzero advance");

  a_open_zero_diff: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[22:1] == 22'd0 && out_tdata[25:23] != 3'd0)
    else $error("undecided item with difference or no advance");

  a_ready_follows_sink: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("pipeline stalled while sink ready");
`endif

endmodule

@@ tb/tb_utf8_caseless_char_compare_core.sv @@
// self-checking testbench for the caseless utf-8 character pair compare core
`timescale 1ns / 100ps

module tb_utf8_caseless_char_compare_core;
  import u8cc_pkg::*;

  typedef struct packed {
    logic                    decided;
    logic signed [DiffW-1:0] difference;
    logic [AdvW-1:0]         adv_a;
    logic [AdvW-1:0]         adv_b;
  } verdict_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;   // bytes_a[31:0], bytes_b[63:32]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // decided[0], difference[22:1], advance_a[25:23], advance_b[28:26]

  verdict_t verdict_q[$];
  int       tx_idle_pct    = 0;
  int       rx_idle_pct    = 0;
  int       rx_hold_cycles = 0;
  int       stall_req      = 0;
  int       stall_ack      = 0;
  int       mismatches     = 0;
  int       items_in       = 0;
  int       results_seen   = 0;
  int       decided_seen   = 0;

  // upper / lower pairs, mostly ones that fold outside the regular patterns
  logic [CpW-1:0] fold_pairs [24] = '{
    21'h178, 21'h0ff, 21'h187, 21'h188, 21'h18e, 21'h1dd, 21'h1b7, 21'h292,
    21'h1c4, 21'h1c6, 21'h1c5, 21'h1c6, 21'h1f7, 21'h1bf, 21'h220, 21'h19e,
    21'h23d, 21'h19a, 21'h243, 21'h180, 21'h1f1, 21'h1f3, 21'h139, 21'h13a
  };

  utf8_caseless_char_compare_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [LenW-1:0] seq_length(input logic [7:0] lead);
    casez (lead)
      8'b0???????: return LenOne;
      8'b110?????: return LenTwo;
      8'b1110????: return LenThree;
      8'b11110???: return LenFour;
      default:     return LenInvalid;
    endcase
  endfunction

  function automatic logic [CpW-1:0] code_point(input logic [31:0] w, input logic [LenW-1:0] n);
    logic [7:0]     c1, c2, c3;
    logic [CpW-1:0] cp;
    c1 = w[15:8];
    c2 = w[23:16];
    c3 = w[31:24];
    cp = CpReplace;
    case (n)
      LenOne:   cp = {13'd0, w[7:0]};
      LenTwo:   if (c1 != 8'd0) cp = {10'd0, w[4:0], c1[5:0]};
      LenThree: if (c1 != 8'd0 && c2 != 8'd0) cp = {5'd0, w[3:0], c1[5:0], c2[5:0]};
      LenFour:  if (c1 != 8'd0 && c2 != 8'd0 && c3 != 8'd0)
                  cp = {w[2:0], c1[5:0], c2[5:0], c3[5:0]};
      default:  cp = CpReplace;
    endcase
    return cp;
  endfunction

  function automatic logic between(input logic [CpW-1:0] c, input int lo, input int hi);
    return int'(c) >= lo && int'(c) <= hi;
  endfunction

  function automatic logic [CpW-1:0] lower_latin(input logic [CpW-1:0] c);
    if (between(c, 'h41, 'h5a) || between(c, 'hc0, 'hd6) || between(c, 'hd8, 'hde))
      return c + 21'd32;
    if (between(c, 'h100, 'h12f) || between(c, 'h132, 'h137) || between(c, 'h14a, 'h177) ||
        between(c, 'h182, 'h185) || between(c, 'h1a0, 'h1a5) || between(c, 'h1de, 'h1ef) ||
        between(c, 'h1f8, 'h21f) || between(c, 'h222, 'h233) || between(c, 'h246, 'h24f))
      return c & ~21'd1;
    if (between(c, 'h139, 'h148) || between(c, 'h179, 'h17e) ||
        between(c, 'h1b3, 'h1b6) || between(c, 'h1cd, 'h1dc))
      return (c + 21'd1) & ~21'd1;
    case (c)
      21'h178: return 21'h0ff;
      21'h187: return 21'h188;
      21'h18b: return 21'h18c;
      21'h18e: return 21'h1dd;
      21'h191: return 21'h192;
      21'h198: return 21'h199;
      21'h1a7: return 21'h1a8;
      21'h1ac: return 21'h1ad;
      21'h1af: return 21'h1b0;
      21'h1b7: return 21'h292;
      21'h1b8: return 21'h1b9;
      21'h1bc: return 21'h1bd;
      21'h1c4, 21'h1c5: return 21'h1c6;
      21'h1c7, 21'h1c8: return 21'h1c9;
      21'h1ca, 21'h1cb: return 21'h1cc;
      21'h1f1, 21'h1f2: return 21'h1f3;
      21'h1f4: return 21'h1f5;
      21'h1f7: return 21'h1bf;
      21'h220: return 21'h19e;
      21'h23b: return 21'h23c;
      21'h23d: return 21'h19a;
      21'h241: return 21'h242;
      21'h243: return 21'h180;
      default: return c;
    endcase
  endfunction

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic [AdvW-1:0] advance_len(input logic [31:0] w, input logic [LenW-1:0] n);
    logic [AdvW-1:0] k;
    k = '0;
    for (int i = 0; i < 4; i++) begin
      if (int'(k) == i && i < int'(n) && w[8*i +: 8] != 8'd0) k = k + 3'd1;
    end
    return k;
  endfunction

  function automatic verdict_t compare_char_pair(input logic [31:0] wa, input logic [31:0] wb);
    verdict_t       v;
    logic [LenW-1:0] la, lb;
    logic [CpW-1:0] ca, cb;
    logic           done;
    int             diff;
    done = 1'b0;
    diff = 0;
    if (wa[7:0] == 8'd0 && wb[7:0] == 8'd0) begin
      done = 1'b1;
    end else if (wa[7:0] == 8'd0) begin
      done = 1'b1;
      diff = 1;
    end else if (wb[7:0] == 8'd0) begin
      done = 1'b1;
      diff = -1;
    end
    la = seq_length(wa[7:0]);
    lb = seq_length(wb[7:0]);
    if (!done) begin
      if (la == LenOne && lb == LenOne) begin
        ca = {13'd0, lower_ascii(wa[7:0])};
        cb = {13'd0, lower_ascii(wb[7:0])};
        if (ca != cb) begin
          done = 1'b1;
          diff = int'(ca) - int'(cb);
        end
      end else if (la == LenInvalid || lb == LenInvalid) begin
        done = 1'b1;
        diff = int'(la) - int'(lb);
      end else begin
        ca = code_point(wa, la);
        cb = code_point(wb, lb);
        if (ca != cb) begin
          ca = lower_latin(ca);
          cb = lower_latin(cb);
          if (ca != cb) begin
            done = 1'b1;
            diff = int'(ca) - int'(cb);
          end
        end
      end
    end
    v.decided    = done;
    v.difference = diff[DiffW-1:0];
    v.adv_a      = done ? '0 : advance_len(wa, la);
    v.adv_b      = done ? '0 : advance_len(wb, lb);
    return v;
  endfunction

  function automatic logic [31:0] utf8_word(input logic [CpW-1:0] cp);
    logic [31:0]     w;
    logic [LenW-1:0] n;
    w = $urandom;
    if (cp < 21'h80) begin
      w[7:0] = cp[7:0];
      n = LenOne;
    end else if (cp < 21'h800) begin
      w[15:0] = {2'b10, cp[5:0], 3'b110, cp[10:6]};
      n = LenTwo;
    end else if (cp < 21'h10000) begin
      w[23:0] = {2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      n = LenThree;
    end else begin
      w = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
      n = LenFour;
    end
    // string often ends right after the character
    if ($urandom_range(0, 3) == 0) begin
      for (int i = 1; i < 4; i++) if (i >= int'(n)) w[8*i +: 8] = 8'd0;
    end
    return w;
  endfunction

  function automatic logic [CpW-1:0] pick_code_point();
    case ($urandom_range(0, 6))
      0:       return CpW'($urandom_range(1, 'h7f));
      1, 2, 3: return CpW'($urandom_range('hc0, 'h2ff));
      4:       return CpW'($urandom_range('h80, 'h7ff));
      5:       return CpW'($urandom_range('h800, 'hffff));
      default: return CpW'($urandom_range('h10000, 'h1fffff));
    endcase
  endfunction

  task automatic make_random_pair(output logic [31:0] wa, output logic [31:0] wb);
    logic [CpW-1:0] ca, cb;
    logic [31:0]    t;
    int             r, k;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      if ($urandom_range(0, 4) == 0) begin
        k  = $urandom_range(0, 11);
        ca = fold_pairs[2*k];
        cb = fold_pairs[2*k+1];
      end else begin
        ca = pick_code_point();
        case ($urandom_range(0, 5))
          0:       cb = ca;
          1:       cb = ca ^ 21'h20;
          2:       cb = ca ^ 21'h1;
          3:       cb = ca + 21'd1;
          default: cb = pick_code_point();
        endcase
      end
      wa = utf8_word(ca);
      wb = utf8_word(cb);
    end else if (r < 80) begin
      wa = $urandom;
      wb = $urandom;
    end else if (r < 92) begin
      wa = utf8_word(pick_code_point());
      wb = utf8_word(pick_code_point());
      case ($urandom_range(0, 3))
        0:       wa[8*$urandom_range(1, 3) +: 8] = 8'd0;
        1:       wa[7:0] = ($urandom_range(0, 1) == 0) ? 8'h80 | 8'($urandom_range(0, 63))
                                                      : 8'hf8 | 8'($urandom_range(0, 7));
        2: begin
          k  = $urandom_range(1, 'h7f);
          wa[15:0] = {2'b10, 6'(k), 7'b1100000, 1'(k >> 6)};
        end
        default: wa[8*$urandom_range(1, 3) +: 8] = 8'd0;
      endcase
    end else begin
      wa = utf8_word(pick_code_point());
      wb = utf8_word(pick_code_point());
      case ($urandom_range(0, 2))
        0:       wa[7:0] = 8'd0;
        1:       wb[7:0] = 8'd0;
        default: begin wa[7:0] = 8'd0; wb[7:0] = 8'd0; end
      endcase
    end
    if ($urandom_range(0, 1) == 1) begin
      t  = wa;
      wa = wb;
      wb = t;
    end
  endtask

  task automatic send_pair(input logic [31:0] wa, input logic [31:0] wb);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {wb, wa};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic report(input string field, input int exp_v, input int act_v);
    $display("%0t mismatch %s expected %0d actual %0d", $time, field, exp_v, act_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (stall_ack != stall_req) begin
      stall_ack      <= stall_req;
      out_tready     <= 1'b0;
      rx_hold_cycles <= 80;
    end else if (rx_hold_cycles > 0) begin
      out_tready     <= 1'b0;
      rx_hold_cycles <= rx_hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    verdict_t  exp_v;
    u8cc_out_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        results_seen++;
        if (got.decided) decided_seen++;
        if (verdict_q.size() == 0) begin
          $display("%0t unexpected item on output, actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (got.decided !== exp_v.decided)
            report("decided", exp_v.decided, got.decided);
          if (got.difference !== exp_v.difference)
            report("difference", exp_v.difference, got.difference);
          if (got.advance_a !== exp_v.adv_a) report("advance_a", exp_v.adv_a, got.advance_a);
          if (got.advance_b !== exp_v.adv_b) report("advance_b", exp_v.adv_b, got.advance_b);
        end
      end
      if (in_tvalid && in_tready) begin
        verdict_q.push_back(compare_char_pair(in_tdata[31:0], in_tdata[63:32]));
        items_in++;
      end
    end
  end

  task automatic test_terminators();
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'hffff_ff00, 32'h0000_0041);
    send_pair(32'h0000_0041, 32'h1234_5600);
  endtask

  task automatic test_ascii_folding();
    send_pair(32'h0000_0061, 32'h0000_0041);
    send_pair(32'h0000_005a, 32'h0000_007b);
    send_pair(32'h0000_007f, 32'h0000_0001);
    send_pair(32'h0000_0040, 32'h0000_0060);
  endtask

  task automatic test_invalid_leads();
    send_pair(32'h0000_0080, 32'h0000_0041);
    send_pair(32'h0000_00ff, 32'h0000_00f8);
    send_pair(32'h0000_a9c3, 32'h0000_00bf);
    send_pair(32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_multibyte_folding();
    send_pair(32'h0000_89c3, 32'h0000_a9c3);
    send_pair(32'h0000_b8c5, 32'h0000_bfc3);
    send_pair(32'h0000_b7c6, 32'h0000_92ca);
    send_pair(32'h0000_83c9, 32'h0000_80c6);
    send_pair(32'h0000_8fc9, 32'h0000_8ec9);
    send_pair(32'h0000_84c7, 32'h0000_85c7);
    send_pair(32'h0000_b9c4, 32'h0000_bac4);
    send_pair(32'h0000_9fc3, 32'h0000_bfc3);
    // overlong two-byte form of an ascii letter
    send_pair(32'h0000_81c1, 32'h0000_0061);
    send_pair(32'hbfbf_bff7, 32'h0000_0041);
    send_pair(32'hbfbf_bff7, 32'h0000_0001);
  endtask

  task automatic test_truncated_sequences();
    send_pair(32'h0000_82e2, 32'h00bd_bfef);
    send_pair(32'h0098_9ff0, 32'h0000_0061);
    send_pair(32'h0000_00c3, 32'h0000_bdbf);
  endtask

  task automatic test_random_text(input int count);
    logic [31:0] wa, wb;
    for (int n = 0; n < count; n++) begin
      make_random_pair(wa, wb);
      send_pair(wa, wb);
    end
  endtask

  task automatic test_output_stall();
    logic [31:0] wa, wb;
    tx_idle_pct = 0;
    stall_req++;
    for (int n = 0; n < 40; n++) begin
      make_random_pair(wa, wb);
      send_pair(wa, wb);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 23;
    rx_idle_pct = 55;
    test_terminators();
    test_ascii_folding();
    test_invalid_leads();
    test_multibyte_folding();
    test_truncated_sequences();
    test_random_text(520);

    tx_idle_pct = 55;
    rx_idle_pct = 23;
    test_random_text(520);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_text(520);
    test_output_stall();

    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $display("%0t %0d expected items never arrived", $time, verdict_q.size());
    end

    $display("sent %0d char pairs (terminators, ascii, invalid leads, multibyte folds,",
             items_in);
    $display("  truncation, noise, output stall); %0d results checked, %0d decided",
             results_seen, decided_seen);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ utf8_caseless_char_compare_core.f @@
rtl/u8cc_pkg.sv
rtl/utf8_caseless_char_compare_core.sv
tb/tb_utf8_caseless_char_compare_core.sv
